@@ hdl/ceazs_pkg.sv @@
// ----------------------------------------------------------------------------
// ceazs_pkg
// Shared types, constants and the channel mapping for the calorimeter
// energy accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ceazs_pkg;

  localparam int CH_NUM_W = 10;   // reported channel number
  localparam int MAP_W    = 11;   // mapped channel before range check (max 1831 for a known kind)
  localparam int OUT_E_W  = 32;   // reported energies

  localparam logic CMD_HIT     = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  typedef enum logic [1:0] {
    KIND_MAIN  = 2'd0,
    KIND_EXTRA = 2'd1,
    KIND_VETO  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam int MAIN_SIDE_STRIDE = 260;
  localparam int MAIN_COL_STRIDE  = 13;
  localparam int EXTRA_BASE       = 520;
  localparam int EXTRA_A_STRIDE   = 64;
  localparam int EXTRA_B_STRIDE   = 32;
  localparam int EXTRA_C_STRIDE   = 16;
  localparam int VETO_BASE        = 648;
  localparam int VETO_A_STRIDE    = 32;
  localparam int VETO_B_STRIDE    = 16;

  // controller to datapath
  typedef struct packed {
    logic item_ready;
    logic clr_write;
    logic flag_bad;
    logic hit_read;
    logic hit_write;
    logic scan_read;
    logic scan_skip;
    logic report;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_valid;
    logic item_readout;
    logic item_bad;
    logic clr_last;
    logic scan_end;
    logic entry_nonzero;
    logic out_free;
  } ctrl_sts_t;

  // Map geometry indices to a channel; an unknown kind maps to all ones,
  // which lies above any channel count.
  function automatic logic [MAP_W-1:0] map_channel(
    input logic [1:0] kind,
    input logic       a,
    input logic [4:0] b,
    input logic [3:0] c,
    input logic [3:0] d
  );
    logic [MAP_W-1:0] ch;
    unique case (kind_t'(kind))
      KIND_MAIN: begin
        ch = MAP_W'(a) * MAP_W'(MAIN_SIDE_STRIDE) + MAP_W'(b) * MAP_W'(MAIN_COL_STRIDE)
           + MAP_W'(c);
      end
      KIND_EXTRA: begin
        ch = MAP_W'(EXTRA_BASE) + MAP_W'(a) * MAP_W'(EXTRA_A_STRIDE)
           + MAP_W'(b) * MAP_W'(EXTRA_B_STRIDE) + MAP_W'(c) * MAP_W'(EXTRA_C_STRIDE)
           + MAP_W'(d);
      end
      KIND_VETO: begin
        ch = MAP_W'(VETO_BASE) + MAP_W'(a) * MAP_W'(VETO_A_STRIDE)
           + MAP_W'(b) * MAP_W'(VETO_B_STRIDE) + MAP_W'(c);
      end
      KIND_NONE: begin
        ch = '1;
      end
      default: begin
        ch = '1;
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ceazs_item_if.sv @@
// ----------------------------------------------------------------------------
// ceazs_item_if
// Input channel: hit and readout request words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceazs_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  detector_kind;
  logic        index_a;
  logic [4:0]  index_b;
  logic [3:0]  index_c;
  logic [3:0]  index_d;
  logic [31:0] hit_energy;

  modport source (
    output valid, cmd, detector_kind, index_a, index_b, index_c, index_d, hit_energy,
    input  ready
  );
  modport sink (
    input  valid, cmd, detector_kind, index_a, index_b, index_c, index_d, hit_energy,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/ceazs_result_if.sv @@
// ----------------------------------------------------------------------------
// ceazs_result_if
// Output channel: readout entry and done words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceazs_result_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [9:0]  channel_number;
  logic [31:0] channel_energy;
  logic [31:0] running_total;
  logic        readout_done;
  logic        event_empty;
  logic        bad_hit_seen;

  modport source (
    output valid, entry_valid, channel_number, channel_energy, running_total,
           readout_done, event_empty, bad_hit_seen,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, channel_number, channel_energy, running_total,
           readout_done, event_empty, bad_hit_seen,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/ceazs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ceazs_ctrl
// Sequencer: clearing pass, hit read-modify-write and readout scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ceazs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  ceazs_pkg::ctrl_sts_t  sts,
  output ceazs_pkg::ctrl_cmd_t  cmd
);
  import ceazs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HIT,
    S_HIT_WR,
    S_SCAN_RD,
    S_SCAN_CHK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.item_ready = 1'b1;
        if (sts.item_valid) begin
          state_next = sts.item_readout ? S_SCAN_RD : S_HIT;
        end
      end
      S_HIT: begin
        if (sts.item_bad) begin
          cmd.flag_bad = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.hit_read = 1'b1;
          state_next   = S_HIT_WR;
        end
      end
      S_HIT_WR: begin
        cmd.hit_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          // hold until the result register is free
          if (sts.out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.entry_nonzero) begin
          if (sts.out_free) begin
            cmd.report = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_skip = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ceazs_dpath.sv @@
// ----------------------------------------------------------------------------
// ceazs_dpath
// Channel store, scan pointer, running total, flags and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ceazs_dpath #(
  parameter int CHANNELS    = 712,
  parameter int ENERGY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  ceazs_item_if.sink            item,
  ceazs_result_if.source        result,
  input  ceazs_pkg::ctrl_cmd_t  cmd,
  output ceazs_pkg::ctrl_sts_t  sts
);
  import ceazs_pkg::*;

  localparam int AW = $clog2(CHANNELS);
  localparam int PW = $clog2(CHANNELS + 1);
  localparam int EW = ENERGY_BITS;
  localparam int WW = (EW > OUT_E_W) ? EW : OUT_E_W;
  localparam logic [WW-1:0] E_MAX_W   = WW'({EW{1'b1}});
  localparam logic [WW-1:0] OUT_MAX_W = WW'({OUT_E_W{1'b1}});

  function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] x, input logic [EW-1:0] y);
    logic [EW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[EW] ? {EW{1'b1}} : s[EW-1:0];
  endfunction

  function automatic logic [OUT_E_W-1:0] clamp_out(input logic [EW-1:0] v);
    logic [WW-1:0] vw;
    vw = WW'(v);
    return (vw > OUT_MAX_W) ? {OUT_E_W{1'b1}} : OUT_E_W'(vw);
  endfunction

  logic [MAP_W-1:0]   map_ch;
  logic               map_bad;
  logic [WW-1:0]      e_in_w;
  logic               load_item;

  logic [AW-1:0]      hit_addr;
  logic               hit_bad;
  logic [EW-1:0]      hit_e;

  logic [EW-1:0]      mem [CHANNELS];
  logic [EW-1:0]      rd_data;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  logic [AW-1:0]      clr_ptr;
  logic [PW-1:0]      scan_ptr;
  logic [EW-1:0]      total;
  logic               any_rep;
  logic               bad_flag;
  logic [EW-1:0]      hit_sum;
  logic [EW-1:0]      total_sum;

  logic               res_valid;
  logic               res_entry;
  logic [CH_NUM_W-1:0] res_channel;
  logic [OUT_E_W-1:0] res_energy;
  logic [OUT_E_W-1:0] res_total;
  logic               res_done;
  logic               res_empty;
  logic               res_bad;

  assign map_ch    = map_channel(item.detector_kind, item.index_a, item.index_b,
                                 item.index_c, item.index_d);
  assign map_bad   = (item.detector_kind == KIND_NONE) || (map_ch >= MAP_W'(CHANNELS));
  assign e_in_w    = WW'(item.hit_energy);
  assign load_item = item.valid && cmd.item_ready;
  assign item.ready = cmd.item_ready;

  // latch the hit word
  always_ff @(posedge clk) begin
    if (load_item) begin
      hit_addr <= map_ch[AW-1:0];
      hit_bad  <= map_bad;
      hit_e    <= (e_in_w > E_MAX_W) ? {EW{1'b1}} : EW'(e_in_w);
    end
  end

  assign hit_sum   = sat_add(rd_data, hit_e);
  assign total_sum = sat_add(total, rd_data);

  assign we    = cmd.clr_write || cmd.hit_write || cmd.report;
  assign waddr = cmd.clr_write ? clr_ptr : (cmd.hit_write ? hit_addr : scan_ptr[AW-1:0]);
  assign wdata = cmd.hit_write ? hit_sum : '0;
  assign re    = cmd.hit_read || cmd.scan_read;
  assign raddr = cmd.hit_read ? hit_addr : scan_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      scan_ptr  <= '0;
      total     <= '0;
      any_rep   <= 1'b0;
      bad_flag  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clr_write) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (cmd.flag_bad) begin
        bad_flag <= 1'b1;
      end
      if (cmd.scan_skip) begin
        scan_ptr <= scan_ptr + PW'(1);
      end
      if (cmd.report) begin
        scan_ptr <= scan_ptr + PW'(1);
        total    <= total_sum;
        any_rep  <= 1'b1;
      end
      if (cmd.finish) begin
        scan_ptr <= '0;
        total    <= '0;
        any_rep  <= 1'b0;
        bad_flag <= 1'b0;
      end
      if (cmd.report || cmd.finish) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      res_entry   <= 1'b1;
      res_channel <= CH_NUM_W'(scan_ptr[AW-1:0]);
      res_energy  <= clamp_out(rd_data);
      res_total   <= clamp_out(total_sum);
      res_done    <= 1'b0;
      res_empty   <= 1'b0;
      res_bad     <= bad_flag;
    end else if (cmd.finish) begin
      res_entry   <= 1'b0;
      res_channel <= '0;
      res_energy  <= '0;
      res_total   <= clamp_out(total);
      res_done    <= 1'b1;
      res_empty   <= !any_rep;
      res_bad     <= bad_flag;
    end
  end

  assign result.valid          = res_valid;
  assign result.entry_valid    = res_entry;
  assign result.channel_number = res_channel;
  assign result.channel_energy = res_energy;
  assign result.running_total  = res_total;
  assign result.readout_done   = res_done;
  assign result.event_empty    = res_empty;
  assign result.bad_hit_seen   = res_bad;

  assign sts.item_valid    = item.valid;
  assign sts.item_readout  = (item.cmd == CMD_READOUT);
  assign sts.item_bad      = hit_bad;
  assign sts.clr_last      = (clr_ptr == AW'(CHANNELS - 1));
  assign sts.scan_end      = (scan_ptr == PW'(CHANNELS));
  assign sts.entry_nonzero = (rd_data != '0);
  assign sts.out_free      = !res_valid || result.ready;

endmodule

`default_nettype wire

@@ hdl/channel_energy_accumulate_zero_suppress_core.sv @@
// Hit word: accept, read the channel, write the sum, then take the next word; a dropped
//   hit is flagged instead of read and written.
// Readout word: accept, then read and check channels from the scan pointer; the result
//   register loads on the check that finds energy, or a done word when the scan ends.
// Results wait in an output register; a full register stalls only the next readout.
// Reset (synchronous): a clearing pass zeroes every channel of the store, item.ready low.
// ----------------------------------------------------------------------------
// channel_energy_accumulate_zero_suppress_core
// Calorimeter event builder: maps hits to channels, accumulates energy per
// channel with saturation and reads out nonzero channels in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_energy_accumulate_zero_suppress_core #(
  parameter int CHANNELS    = 712,
  parameter int ENERGY_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  ceazs_item_if.sink     item,
  ceazs_result_if.source result
);
  import ceazs_pkg::*;

  // Command and status between sequencer and datapath. The sequencer owns
  // item.ready (open only in its idle state) and decides each memory access;
  // the datapath owns the single-port-write, single-port-read channel store.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer: clearing pass after reset, then per word either a hit
  // read-modify-write or a scan that reads and checks one channel at a time.
  ceazs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Datapath: channel mapping and range check, store, scan pointer,
  // saturating running total, sticky bad-hit flag and the result register.
  ceazs_dpath #(
    .CHANNELS    (CHANNELS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

@@ hdl/ceazs_checker.sv @@
// ----------------------------------------------------------------------------
// ceazs_checker
// Port-level checks on the event builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ceazs_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        entry_valid,
  input logic [9:0]  channel_number,
  input logic [31:0] channel_energy,
  input logic [31:0] running_total,
  input logic        readout_done,
  input logic        event_empty,
  input logic        bad_hit_seen
);

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(entry_valid)
      && $stable(channel_number) && $stable(channel_energy) && $stable(running_total)
      && $stable(readout_done) && $stable(event_empty) && $stable(bad_hit_seen))
    else $error("result word changed while stalled");

  // every word is either an entry or a done word
  a_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (entry_valid != readout_done))
    else $error("result word is neither entry nor done");

  // done word carries no channel
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && readout_done |-> channel_number == 10'd0 && channel_energy == 32'd0)
    else $error("done word carries channel data");

  // zero suppression: an entry always has energy and never flags empty
  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && entry_valid |-> channel_energy != 32'd0 && !event_empty)
    else $error("entry word with zero energy or empty flag");

  // store is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !item_ready)
    else $error("input open during clearing pass");

endmodule

bind channel_energy_accumulate_zero_suppress_core ceazs_checker u_ceazs_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .entry_valid    (result.entry_valid),
  .channel_number (result.channel_number),
  .channel_energy (result.channel_energy),
  .running_total  (result.running_total),
  .readout_done   (result.readout_done),
  .event_empty    (result.event_empty),
  .bad_hit_seen   (result.bad_hit_seen)
);

`default_nettype wire
